FILE: rtl/bcpe_pkg.sv
package bcpe_pkg;

    // default list depth
    localparam int MAX_POINTS_DEF = 16;

    localparam int COORD_W = 16;
    localparam int T_W     = 17;
    localparam int COUNT_W = 5;

    // 1.0 in Q1.16
    localparam logic [T_W-1:0] T_ONE = 17'd65536;

    // item modes
    localparam logic [1:0] MODE_APPEND = 2'd0;
    localparam logic [1:0] MODE_REMOVE = 2'd1;
    localparam logic [1:0] MODE_EVAL   = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FEW   = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } point_t;

endpackage

FILE: rtl/bezier_curve_point_evaluator_unit.sv
// bezier curve point evaluator: keeps an ordered list of up to MAX_POINTS control
// points (x, y in signed q2.14) and takes one command word when start is high and
// busy is low. mode 0 appends a point (status 2 when the list is full), mode 1
// drops the last point (status 3 when empty), mode 2 evaluates the curve at
// t_value (q1.16, 65536 = 1.0, larger values clamp to 1.0) by de casteljau
// interpolation, each step rounded to nearest and saturated; fewer than two points
// gives status 1. every command returns exactly one result word, marked by a
// one-cycle done strobe: the receiver cannot stall, so it must take the word in
// that cycle. append, remove and a refused evaluation answer in the cycle after
// the command and leave busy low. an evaluation over n points runs n-1 passes over
// the stored points through one shared interpolation unit (a multiplier pair per
// coordinate, two pipeline stages); each pass reads one point per cycle from the
// point memory and drains the unit before the next pass. busy is high while the
// evaluation runs and low again in the cycle of the result word. curve_x and
// curve_y are zero unless an evaluation succeeds; count_now is the list length
// after the command.
module bezier_curve_point_evaluator_unit #(
    parameter int MAX_POINTS = bcpe_pkg::MAX_POINTS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          mode,
    input  logic signed [bcpe_pkg::COORD_W-1:0] point_x,
    input  logic signed [bcpe_pkg::COORD_W-1:0] point_y,
    input  logic [bcpe_pkg::T_W-1:0]            t_value,
    output logic                                done,
    output logic signed [bcpe_pkg::COORD_W-1:0] curve_x,
    output logic signed [bcpe_pkg::COORD_W-1:0] curve_y,
    output logic [bcpe_pkg::COUNT_W-1:0]        count_now,
    output logic [1:0]                          status
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);

    // one-hot sequencer states
    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_READ  = 3'b010,
        S_DRAIN = 3'b100
    } state_t;

    state_t                       state_reg,    state_next;
    logic [CW-1:0]                count_reg,    count_next;
    logic [CW-1:0]                pass_len_reg, pass_len_next;
    logic [AW-1:0]                rd_idx_reg,   rd_idx_next;
    logic [1:0]                   drain_reg,    drain_next;
    logic                         src_work_reg, src_work_next;
    logic [bcpe_pkg::T_W-1:0]     t_reg,        t_next;

    // read-data stage tracking
    logic                         rv_reg;
    logic [AW-1:0]                ridx_reg;
    bcpe_pkg::point_t             prev_reg;

    // result word registers
    logic                         done_reg,     done_next;
    bcpe_pkg::point_t             res_reg,      res_next;
    logic [bcpe_pkg::COUNT_W-1:0] cnt_out_reg,  cnt_out_next;
    logic [1:0]                   status_reg,   status_next;

    logic                         accept;
    logic                         ctrl_we;
    logic                         rd_en;
    logic                         last_read;
    bcpe_pkg::point_t             new_point;
    bcpe_pkg::point_t             rd_data;

    logic                         lerp_in_valid;
    logic [AW-1:0]                lerp_in_tag;
    logic                         lerp_out_valid;
    bcpe_pkg::point_t             lerp_out_point;
    logic [AW-1:0]                lerp_out_tag;

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;

    assign new_point.x = point_x;
    assign new_point.y = point_y;

    assign rd_en     = (state_reg == S_READ);
    assign last_read = (CW'(rd_idx_reg) == pass_len_reg - CW'(1));

    // each read after the first in a pass pairs with the previous point
    assign lerp_in_valid = rv_reg && (ridx_reg != '0);
    assign lerp_in_tag   = ridx_reg - AW'(1);

    bcpe_point_store #(
        .DEPTH      (MAX_POINTS)
    ) u_store (
        .clk        (clk),
        .ctrl_we    (ctrl_we),
        .ctrl_waddr (count_reg[AW-1:0]),
        .ctrl_wdata (new_point),
        .work_we    (lerp_out_valid),
        .work_waddr (lerp_out_tag),
        .work_wdata (lerp_out_point),
        .rd_en      (rd_en),
        .rd_work    (src_work_reg),
        .rd_addr    (rd_idx_reg),
        .rd_data    (rd_data)
    );

    bcpe_lerp_unit #(
        .TAG_W      (AW)
    ) u_lerp (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (lerp_in_valid),
        .t          (t_reg),
        .a          (prev_reg),
        .b          (rd_data),
        .in_tag     (lerp_in_tag),
        .out_valid  (lerp_out_valid),
        .out_point  (lerp_out_point),
        .out_tag    (lerp_out_tag)
    );

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        pass_len_next = pass_len_reg;
        rd_idx_next   = rd_idx_reg;
        drain_next    = drain_reg;
        src_work_next = src_work_reg;
        t_next        = t_reg;
        done_next     = 1'b0;
        res_next      = res_reg;
        cnt_out_next  = cnt_out_reg;
        status_next   = status_reg;
        ctrl_we       = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_next    = '0;
                    status_next = bcpe_pkg::ST_OK;
                    done_next   = 1'b1;
                    if (mode == bcpe_pkg::MODE_APPEND)
                    begin
                        if (count_reg == CW'(MAX_POINTS))
                        begin
                            status_next = bcpe_pkg::ST_FULL;
                        end
                        else
                        begin
                            ctrl_we    = 1'b1;
                            count_next = count_reg + CW'(1);
                        end
                    end
                    else if (mode == bcpe_pkg::MODE_REMOVE)
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = bcpe_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            count_next = count_reg - CW'(1);
                        end
                    end
                    else if (mode == bcpe_pkg::MODE_EVAL)
                    begin
                        if (count_reg < CW'(2))
                        begin
                            status_next = bcpe_pkg::ST_FEW;
                        end
                        else
                        begin
                            // result comes at the end of the last pass
                            done_next     = 1'b0;
                            state_next    = S_READ;
                            pass_len_next = count_reg;
                            rd_idx_next   = '0;
                            src_work_next = 1'b0;
                            t_next        = (t_value > bcpe_pkg::T_ONE) ?
                                            bcpe_pkg::T_ONE : t_value;
                        end
                    end
                    cnt_out_next = bcpe_pkg::COUNT_W'(count_next);
                end
            end

            S_READ:
            begin
                rd_idx_next = rd_idx_reg + AW'(1);
                if (last_read)
                begin
                    state_next = S_DRAIN;
                    drain_next = '0;
                end
            end

            S_DRAIN:
            begin
                drain_next = drain_reg + 2'd1;
                // last write of the pass lands on this edge
                if (drain_reg == 2'd2)
                begin
                    if (pass_len_reg == CW'(2))
                    begin
                        state_next = S_IDLE;
                        done_next  = 1'b1;
                        res_next   = lerp_out_point;
                    end
                    else
                    begin
                        state_next    = S_READ;
                        pass_len_next = pass_len_reg - CW'(1);
                        rd_idx_next   = '0;
                        src_work_next = 1'b1;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
            rv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
            rv_reg    <= rd_en;
        end
    end

    always_ff @(posedge clk)
    begin
        pass_len_reg <= pass_len_next;
        rd_idx_reg   <= rd_idx_next;
        drain_reg    <= drain_next;
        src_work_reg <= src_work_next;
        t_reg        <= t_next;
        res_reg      <= res_next;
        cnt_out_reg  <= cnt_out_next;
        status_reg   <= status_next;
        ridx_reg     <= rd_idx_reg;
        if (rv_reg)
        begin
            prev_reg <= rd_data;
        end
    end

    assign done      = done_reg;
    assign curve_x   = res_reg.x;
    assign curve_y   = res_reg.y;
    assign count_now = cnt_out_reg;
    assign status    = status_reg;

endmodule

FILE: rtl/bcpe_point_store.sv
module bcpe_point_store #(
    parameter int DEPTH = bcpe_pkg::MAX_POINTS_DEF,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic                    clk,
    input  logic                    ctrl_we,
    input  logic [AW-1:0]           ctrl_waddr,
    input  bcpe_pkg::point_t        ctrl_wdata,
    input  logic                    work_we,
    input  logic [AW-1:0]           work_waddr,
    input  bcpe_pkg::point_t        work_wdata,
    input  logic                    rd_en,
    input  logic                    rd_work,
    input  logic [AW-1:0]           rd_addr,
    output bcpe_pkg::point_t        rd_data
);

    // stored control points and interpolation scratch
    bcpe_pkg::point_t ctrl_mem [DEPTH];
    bcpe_pkg::point_t work_mem [DEPTH];
    bcpe_pkg::point_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl_we)
        begin
            ctrl_mem[ctrl_waddr] <= ctrl_wdata;
        end
        if (work_we)
        begin
            work_mem[work_waddr] <= work_wdata;
        end
        if (rd_en)
        begin
            if (rd_work)
            begin
                rd_data_reg <= work_mem[rd_addr];
            end
            else
            begin
                rd_data_reg <= ctrl_mem[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/bcpe_lerp_unit.sv
module bcpe_lerp_unit #(
    parameter int TAG_W = 4
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic [bcpe_pkg::T_W-1:0] t,
    input  bcpe_pkg::point_t        a,
    input  bcpe_pkg::point_t        b,
    input  logic [TAG_W-1:0]        in_tag,
    output logic                    out_valid,
    output bcpe_pkg::point_t        out_point,
    output logic [TAG_W-1:0]        out_tag
);

    localparam int PW = 36;

    logic signed [17:0]   ut_s;
    logic signed [17:0]   t_s;
    logic signed [17:0]   ax_s;
    logic signed [17:0]   ay_s;
    logic signed [17:0]   bx_s;
    logic signed [17:0]   by_s;

    logic signed [PW-1:0] pax_reg;
    logic signed [PW-1:0] pbx_reg;
    logic signed [PW-1:0] pay_reg;
    logic signed [PW-1:0] pby_reg;
    logic                 v1_reg;
    logic [TAG_W-1:0]     tag1_reg;

    logic signed [PW-1:0] sum_x;
    logic signed [PW-1:0] sum_y;

    logic                 v2_reg;
    logic [TAG_W-1:0]     tag2_reg;
    bcpe_pkg::point_t     res_reg;

    // floor shift by 16, then clamp to q2.14 range
    function automatic logic signed [15:0] round_sat(input logic signed [PW-1:0] s);
        logic signed [19:0] q;
        q = s[PW-1:16];
        if (q > 20'sd32767)
            return 16'sh7fff;
        else if (q < -20'sd32768)
            return 16'sh8000;
        else
            return q[15:0];
    endfunction

    assign ut_s = $signed({1'b0, bcpe_pkg::T_ONE - t});
    assign t_s  = $signed({1'b0, t});
    assign ax_s = {{2{a.x[15]}}, a.x};
    assign ay_s = {{2{a.y[15]}}, a.y};
    assign bx_s = {{2{b.x[15]}}, b.x};
    assign by_s = {{2{b.y[15]}}, b.y};

    // multiplier pair per coordinate
    always_ff @(posedge clk)
    begin
        pax_reg  <= ut_s * ax_s;
        pbx_reg  <= t_s * bx_s;
        pay_reg  <= ut_s * ay_s;
        pby_reg  <= t_s * by_s;
        tag1_reg <= in_tag;
    end

    assign sum_x = pax_reg + pbx_reg + 36'sd32768;
    assign sum_y = pay_reg + pby_reg + 36'sd32768;

    always_ff @(posedge clk)
    begin
        res_reg.x <= round_sat(sum_x);
        res_reg.y <= round_sat(sum_y);
        tag2_reg  <= tag1_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    assign out_valid = v2_reg;
    assign out_point = res_reg;
    assign out_tag   = tag2_reg;

endmodule
